/* src/acctilt_pkg.sv */
// Shared constants, types and the arctangent table for the accelerometer tilt block.
// Used by the square-root cells, the CORDIC cells, the top level and the checker.
`default_nettype none

package acctilt_pkg;

   // Sample format and precision reduction.
   localparam int SAMPLE_W     = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int SAMPLE_SHIFT = SAMPLE_W - SAMPLE_BITS;

   // Sum of two squares, and its square root with 8 fraction bits.
   localparam int SQ_W   = 2 * SAMPLE_W;
   localparam int ROOT_W = (SQ_W + 16) / 2;
   localparam int REM_W  = ROOT_W + 2;

   // CORDIC operands and angle accumulator (units of 2^-16 degree).
   localparam int NUM_W        = ROOT_W + 1;
   localparam int CORDIC_W     = NUM_W + 3;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int ATAN_IDX_W   = $clog2(ATAN_LEN);
   localparam int ACC_W        = 25;
   localparam int FRAC_SHIFT   = 8;
   localparam int RND_W        = ACC_W + 1 - FRAC_SHIFT;

   localparam int ANGLE_W = 16;
   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;
   localparam logic signed [RND_W-1:0]   RND_LIMIT   = 18'sd23040;
   localparam logic [ACC_W:0]            ROUND_HALF  = 26'd128;

   // Cycles from an accepted start to the result strobe.
   localparam int LATENCY = 4 + ROOT_W + CORDIC_STEPS;

   // Axis selector codes.
   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   typedef logic [ATAN_IDX_W-1:0] atan_idx_type;

   // Square-root cell state: radicand bits still to consume, partial remainder, partial root.
   typedef struct packed {
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   // Item context that travels alongside the square-root chain.
   typedef struct packed {
      logic                       valid;
      logic [1:0]                 sel;
      logic signed [SAMPLE_W-1:0] lin;
   } side_type;

   // CORDIC cell state.
   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ACC_W-1:0]    acc;
   } cordic_type;

   // Item flags that travel alongside the CORDIC chain.
   typedef struct packed {
      logic valid;
      logic special;
      logic invalid;
      logic neg;
   } flag_type;

   // atan(2^-i) in degrees, units of 2^-16 degree, rounded to nearest.
   function automatic logic signed [ACC_W-1:0] atan_entry(input atan_idx_type idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = 25'sd2949120;
         5'd1:    val = 25'sd1740967;
         5'd2:    val = 25'sd919879;
         5'd3:    val = 25'sd466945;
         5'd4:    val = 25'sd234379;
         5'd5:    val = 25'sd117304;
         5'd6:    val = 25'sd58666;
         5'd7:    val = 25'sd29335;
         5'd8:    val = 25'sd14668;
         5'd9:    val = 25'sd7334;
         5'd10:   val = 25'sd3667;
         5'd11:   val = 25'sd1833;
         5'd12:   val = 25'sd917;
         5'd13:   val = 25'sd458;
         5'd14:   val = 25'sd229;
         5'd15:   val = 25'sd115;
         5'd16:   val = 25'sd57;
         5'd17:   val = 25'sd29;
         5'd18:   val = 25'sd14;
         5'd19:   val = 25'sd7;
         5'd20:   val = 25'sd4;
         5'd21:   val = 25'sd2;
         5'd22:   val = 25'sd1;
         default: val = 25'sd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* src/acctilt_sqrt_cell.sv */
// One cell of the square-root chain: settles one root bit per clock.
// Depends on acctilt_pkg for the cell state and side types.
`default_nettype none

module acctilt_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  acctilt_pkg::sqrt_type sq_up,
   input  acctilt_pkg::side_type side_up,
   output acctilt_pkg::sqrt_type sq_dn,
   output acctilt_pkg::side_type side_dn
);

   logic [acctilt_pkg::REM_W+1:0] trial;
   logic [acctilt_pkg::REM_W+1:0] test;
   logic [acctilt_pkg::REM_W+1:0] diff;
   acctilt_pkg::sqrt_type         sq_in;
   acctilt_pkg::sqrt_type         sq_ff;
   acctilt_pkg::side_type         side_ff;

   // Bring down the next two radicand bits and try subtracting 4*root+1.
   always_comb begin
      trial = {sq_up.rem, sq_up.rad[acctilt_pkg::SQ_W-1 -: 2]};
      test  = {2'b00, sq_up.root, 2'b01};
      diff  = trial - test;
      sq_in.rad = {sq_up.rad[acctilt_pkg::SQ_W-3:0], 2'b00};
      if (trial >= test) begin
         sq_in.rem  = diff[acctilt_pkg::REM_W-1:0];
         sq_in.root = {sq_up.root[acctilt_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         sq_in.rem  = trial[acctilt_pkg::REM_W-1:0];
         sq_in.root = {sq_up.root[acctilt_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      side_ff <= side_up;
      if (reset) begin
         side_ff.valid <= 1'b0;
      end
   end

   assign sq_dn   = sq_ff;
   assign side_dn = side_ff;

endmodule

`default_nettype wire

/* src/acctilt_cordic_cell.sv */
// One vectoring CORDIC micro-rotation per clock; the step number selects shift and table entry.
// Depends on acctilt_pkg for the cell state, flag types and the arctangent table.
`default_nettype none

module acctilt_cordic_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  acctilt_pkg::atan_idx_type step_idx,
   input  acctilt_pkg::cordic_type   cord_up,
   input  acctilt_pkg::flag_type     flag_up,
   output acctilt_pkg::cordic_type   cord_dn,
   output acctilt_pkg::flag_type     flag_dn
);

   logic signed [acctilt_pkg::CORDIC_W-1:0] x_cur;
   logic signed [acctilt_pkg::CORDIC_W-1:0] y_cur;
   logic signed [acctilt_pkg::CORDIC_W-1:0] xs;
   logic signed [acctilt_pkg::CORDIC_W-1:0] ys;
   logic signed [acctilt_pkg::ACC_W-1:0]    acc_cur;
   logic signed [acctilt_pkg::ACC_W-1:0]    tab;
   acctilt_pkg::cordic_type                 cord_in;
   acctilt_pkg::cordic_type                 cord_ff;
   acctilt_pkg::flag_type                   flag_ff;

   always_comb begin
      x_cur   = cord_up.x;
      y_cur   = cord_up.y;
      acc_cur = cord_up.acc;
      xs      = x_cur >>> step_idx;
      ys      = y_cur >>> step_idx;
      tab     = acctilt_pkg::atan_entry(step_idx);
      // A non-negative y rotates the vector downward.
      if (!y_cur[acctilt_pkg::CORDIC_W-1]) begin
         cord_in.x   = x_cur + ys;
         cord_in.y   = y_cur - xs;
         cord_in.acc = acc_cur + tab;
      end else begin
         cord_in.x   = x_cur - ys;
         cord_in.y   = y_cur + xs;
         cord_in.acc = acc_cur - tab;
      end
   end

   always_ff @(posedge clock) begin
      cord_ff <= cord_in;
      flag_ff <= flag_up;
      if (reset) begin
         flag_ff.valid <= 1'b0;
      end
   end

   assign cord_dn = cord_ff;
   assign flag_dn = flag_ff;

endmodule

`default_nettype wire

/* src/accel_tilt_angle_top.sv */
// Top level of the accelerometer tilt-angle block: squares, square-root chain, CORDIC chain.
// Depends on acctilt_pkg, acctilt_sqrt_cell and acctilt_cordic_cell.
//
//   Channel   Ports                                          Transfer
//   request   start, busy, req_accel_x/y/z, req_axis_select  edge with start high and busy low
//   response  rsp_valid, rsp_angle_deg, rsp_invalid          edge ending the one cycle of rsp_valid
//
// A new request can be taken on every clock while busy is low; each one passes through a squaring
// register, a summing register, 24 square-root cells, a setup register, 16 CORDIC cells and a
// rounding register before its response. Busy is high only while reset is asserted; reset drops
// every item in flight. The receiver cannot stall, so nothing ever holds the chains.
`default_nettype none

module accel_tilt_angle_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [acctilt_pkg::SAMPLE_W-1:0]  req_accel_x,
   input  logic signed [acctilt_pkg::SAMPLE_W-1:0]  req_accel_y,
   input  logic signed [acctilt_pkg::SAMPLE_W-1:0]  req_accel_z,
   input  logic [1:0]                               req_axis_select,
   output logic                                     rsp_valid,
   output logic signed [acctilt_pkg::ANGLE_W-1:0]   rsp_angle_deg,
   output logic                                     rsp_invalid
);

   // Front end: sample reduction, operand selection and squaring.
   logic signed [acctilt_pkg::SAMPLE_W-1:0] smp_x;
   logic signed [acctilt_pkg::SAMPLE_W-1:0] smp_y;
   logic signed [acctilt_pkg::SAMPLE_W-1:0] smp_z;
   logic signed [acctilt_pkg::SAMPLE_W-1:0] op_a;
   logic signed [acctilt_pkg::SAMPLE_W-1:0] op_b;
   logic signed [acctilt_pkg::SAMPLE_W-1:0] op_lin;
   logic signed [acctilt_pkg::SQ_W-1:0]     op_a_wide;
   logic signed [acctilt_pkg::SQ_W-1:0]     op_b_wide;
   logic signed [acctilt_pkg::SQ_W-1:0]     prod_a;
   logic signed [acctilt_pkg::SQ_W-1:0]     prod_b;
   logic [acctilt_pkg::SQ_W-1:0]            sqa_ff;
   logic [acctilt_pkg::SQ_W-1:0]            sqb_ff;
   acctilt_pkg::side_type                   side0_in;
   acctilt_pkg::side_type                   side0_ff;
   acctilt_pkg::sqrt_type                   sq1_in;
   acctilt_pkg::sqrt_type                   sq1_ff;
   acctilt_pkg::side_type                   side1_ff;

   assign busy = reset;

   always_comb begin
      smp_x  = req_accel_x >>> acctilt_pkg::SAMPLE_SHIFT;
      smp_y  = req_accel_y >>> acctilt_pkg::SAMPLE_SHIFT;
      smp_z  = req_accel_z >>> acctilt_pkg::SAMPLE_SHIFT;
      unique case (req_axis_select)
         acctilt_pkg::AXIS_X: begin
            op_a   = smp_y;
            op_b   = smp_z;
            op_lin = smp_x;
         end
         acctilt_pkg::AXIS_Y: begin
            op_a   = smp_x;
            op_b   = smp_z;
            op_lin = smp_y;
         end
         acctilt_pkg::AXIS_Z: begin
            op_a   = smp_x;
            op_b   = smp_y;
            op_lin = smp_z;
         end
         default: begin
            op_a   = smp_x;
            op_b   = smp_y;
            op_lin = smp_z;
         end
      endcase
      op_a_wide      = {{(acctilt_pkg::SQ_W - acctilt_pkg::SAMPLE_W){op_a[acctilt_pkg::SAMPLE_W-1]}},
                        op_a};
      op_b_wide      = {{(acctilt_pkg::SQ_W - acctilt_pkg::SAMPLE_W){op_b[acctilt_pkg::SAMPLE_W-1]}},
                        op_b};
      prod_a         = op_a_wide * op_a_wide;
      prod_b         = op_b_wide * op_b_wide;
      side0_in.valid = start & ~busy;
      side0_in.sel   = req_axis_select;
      side0_in.lin   = op_lin;
   end

   always_ff @(posedge clock) begin
      sqa_ff   <= prod_a;
      sqb_ff   <= prod_b;
      side0_ff <= side0_in;
      if (reset) begin
         side0_ff.valid <= 1'b0;
      end
   end

   always_comb begin
      sq1_in.rad  = sqa_ff + sqb_ff;
      sq1_in.rem  = '0;
      sq1_in.root = '0;
   end

   always_ff @(posedge clock) begin
      sq1_ff   <= sq1_in;
      side1_ff <= side0_ff;
      if (reset) begin
         side1_ff.valid <= 1'b0;
      end
   end

   // Square-root chain.
   acctilt_pkg::sqrt_type sq_chain   [0:acctilt_pkg::ROOT_W];
   acctilt_pkg::side_type side_chain [0:acctilt_pkg::ROOT_W];

   assign sq_chain[0]   = sq1_ff;
   assign side_chain[0] = side1_ff;

   for (genvar k = 0; k < acctilt_pkg::ROOT_W; k++) begin : g_sqrt
      acctilt_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .sq_up   (sq_chain[k]),
         .side_up (side_chain[k]),
         .sq_dn   (sq_chain[k+1]),
         .side_dn (side_chain[k+1])
      );
   end

   // Setup: build numerator and denominator, flag the special cases.
   acctilt_pkg::side_type                side_q;
   logic signed [acctilt_pkg::NUM_W-1:0] mag;
   logic signed [acctilt_pkg::NUM_W-1:0] lin_ext;
   logic signed [acctilt_pkg::NUM_W-1:0] lin_scaled;
   logic signed [acctilt_pkg::NUM_W-1:0] num_raw;
   logic signed [acctilt_pkg::NUM_W-1:0] den_raw;
   logic signed [acctilt_pkg::NUM_W-1:0] num;
   logic signed [acctilt_pkg::NUM_W-1:0] den;
   acctilt_pkg::cordic_type              cord0_in;
   acctilt_pkg::cordic_type              cord0_ff;
   acctilt_pkg::flag_type                flag0_in;
   acctilt_pkg::flag_type                flag0_ff;

   always_comb begin
      side_q     = side_chain[acctilt_pkg::ROOT_W];
      mag        = {1'b0, sq_chain[acctilt_pkg::ROOT_W].root};
      lin_ext    = {{(acctilt_pkg::NUM_W - acctilt_pkg::SAMPLE_W)
                     {side_q.lin[acctilt_pkg::SAMPLE_W-1]}},
                    side_q.lin};
      lin_scaled = lin_ext <<< acctilt_pkg::FRAC_SHIFT;
      unique case (side_q.sel) inside
         acctilt_pkg::AXIS_X, acctilt_pkg::AXIS_Y: begin
            num_raw = lin_scaled;
            den_raw = mag;
         end
         acctilt_pkg::AXIS_Z: begin
            num_raw = mag;
            den_raw = lin_scaled;
         end
         default: begin
            num_raw = '0;
            den_raw = '0;
         end
      endcase
      // Fold a negative denominator into the right half-plane of the rotation.
      if (den_raw[acctilt_pkg::NUM_W-1]) begin
         num = -num_raw;
         den = -den_raw;
      end else begin
         num = num_raw;
         den = den_raw;
      end
      cord0_in.x   = {{(acctilt_pkg::CORDIC_W - acctilt_pkg::NUM_W){den[acctilt_pkg::NUM_W-1]}},
                      den};
      cord0_in.y   = {{(acctilt_pkg::CORDIC_W - acctilt_pkg::NUM_W){num[acctilt_pkg::NUM_W-1]}},
                      num};
      cord0_in.acc = '0;
      flag0_in.valid   = side_q.valid;
      flag0_in.special = (side_q.sel == acctilt_pkg::AXIS_NONE) || (den == '0);
      flag0_in.invalid = (side_q.sel == acctilt_pkg::AXIS_NONE) || ((den == '0) && (num == '0));
      flag0_in.neg     = num[acctilt_pkg::NUM_W-1];
   end

   always_ff @(posedge clock) begin
      cord0_ff <= cord0_in;
      flag0_ff <= flag0_in;
      if (reset) begin
         flag0_ff.valid <= 1'b0;
      end
   end

   // CORDIC chain.
   acctilt_pkg::cordic_type cord_chain [0:acctilt_pkg::CORDIC_STEPS];
   acctilt_pkg::flag_type   flag_chain [0:acctilt_pkg::CORDIC_STEPS];

   assign cord_chain[0] = cord0_ff;
   assign flag_chain[0] = flag0_ff;

   for (genvar k = 0; k < acctilt_pkg::CORDIC_STEPS; k++) begin : g_cordic
      acctilt_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step_idx (acctilt_pkg::atan_idx_type'(k)),
         .cord_up  (cord_chain[k]),
         .flag_up  (flag_chain[k]),
         .cord_dn  (cord_chain[k+1]),
         .flag_dn  (flag_chain[k+1])
      );
   end

   // Round to Q7.8, clamp, and apply the special cases.
   acctilt_pkg::flag_type                  flag_q;
   logic [acctilt_pkg::ACC_W-1:0]          acc_q;
   logic [acctilt_pkg::ACC_W:0]            rnd_sum;
   logic signed [acctilt_pkg::RND_W-1:0]   rnd_q;
   logic signed [acctilt_pkg::ANGLE_W-1:0] angle_in;
   logic                                   rsp_valid_ff;
   logic signed [acctilt_pkg::ANGLE_W-1:0] rsp_angle_ff;
   logic                                   rsp_invalid_ff;

   always_comb begin
      flag_q  = flag_chain[acctilt_pkg::CORDIC_STEPS];
      acc_q   = cord_chain[acctilt_pkg::CORDIC_STEPS].acc;
      rnd_sum = {acc_q[acctilt_pkg::ACC_W-1], acc_q} + acctilt_pkg::ROUND_HALF;
      rnd_q   = rnd_sum[acctilt_pkg::ACC_W:acctilt_pkg::FRAC_SHIFT];
      if (flag_q.special) begin
         if (flag_q.invalid) begin
            angle_in = '0;
         end else if (flag_q.neg) begin
            angle_in = -acctilt_pkg::ANGLE_LIMIT;
         end else begin
            angle_in = acctilt_pkg::ANGLE_LIMIT;
         end
      end else if (rnd_q > acctilt_pkg::RND_LIMIT) begin
         angle_in = acctilt_pkg::ANGLE_LIMIT;
      end else if (rnd_q < -acctilt_pkg::RND_LIMIT) begin
         angle_in = -acctilt_pkg::ANGLE_LIMIT;
      end else begin
         angle_in = rnd_q[acctilt_pkg::ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_angle_ff   <= angle_in;
      rsp_invalid_ff <= flag_q.invalid;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= flag_q.valid;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_deg = rsp_angle_ff;
   assign rsp_invalid   = rsp_invalid_ff;

endmodule

`default_nettype wire

/* src/acctilt_checker.sv */
// Port-level checks for the accelerometer tilt block, bound to the top level.
// Depends on acctilt_pkg for the latency and angle limit.
`default_nettype none

module acctilt_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic signed [acctilt_pkg::ANGLE_W-1:0] rsp_angle_deg,
   input logic                                   rsp_invalid
);

   // Every accepted request produces its response.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(acctilt_pkg::LATENCY) rsp_valid)
      else $error("accepted request produced no response at the expected cycle");

   // No response appears without a request accepted at the matching cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, acctilt_pkg::LATENCY))
      else $error("response without a matching accepted request");

   // An invalid result always reports a zero angle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_angle_deg == '0))
      else $error("invalid response with a nonzero angle");

   // The angle never leaves plus or minus ninety degrees.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_angle_deg <= acctilt_pkg::ANGLE_LIMIT) &&
                     (rsp_angle_deg >= -acctilt_pkg::ANGLE_LIMIT)))
      else $error("response angle outside the ninety degree limit");

endmodule

bind accel_tilt_angle_top acctilt_checker u_acctilt_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_angle_deg (rsp_angle_deg),
   .rsp_invalid   (rsp_invalid)
);

`default_nettype wire
